/* design/quaternion_to_euler_angles_defines.svh */
// ---------------------------------------------------------------------------
// quaternion to euler angles - assertion macros
// clocked assertion helpers shared by the checker
// ---------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// property sampled on clock, masked while reset is high
`define Q2E_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// overlapping implication built on the macro above
`define Q2E_ASSERT_IMPLIES(label, pre, post, msg) \
   `Q2E_ASSERT_CLK(label, (pre) |-> (post), msg)

`endif

/* design/q2e_pkg.sv */
// ---------------------------------------------------------------------------
// q2e_pkg
// types, widths, constants and helpers of the quaternion to euler pipeline
// ---------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

   localparam int QW    = 16;  // aligned component, q2.14
   localparam int PW    = 32;  // component product, q.28
   localparam int SW    = 35;  // sums and atan2 arguments, q.28
   localparam int AW    = 30;  // clamped arcsine argument
   localparam int RADW  = 57;  // radicand 2^56 - a*a
   localparam int RESW  = 58;  // square root work register
   localparam int ROOTW = 29;  // final root
   localparam int XYW   = 38;  // cordic x and y
   localparam int ZW    = 35;  // cordic angle, q.30
   localparam int SQRT_STEPS = 29;
   localparam int TABLE_LEN  = 24;
   localparam int Q13_SHIFT  = 17;

   localparam logic signed [SW-1:0] ONE_Q28    = 35'sd268435456;
   localparam logic signed [ZW-1:0] PI_Q30     = 35'sd3373259426;
   localparam logic signed [ZW-1:0] ROUND_Q30  = 35'sd65536;
   localparam logic signed [ZW-1:0] PI_Q13     = 35'sd25736;
   localparam logic signed [ZW-1:0] HALF_PI_Q13 = 35'sd12868;

   localparam logic signed [ZW-1:0] ATAN_Q30 [0:TABLE_LEN-1] = '{
      35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
      35'sd67021687, 35'sd33543516, 35'sd16775851, 35'sd8388437,
      35'sd4194283, 35'sd2097149, 35'sd1048576, 35'sd524288,
      35'sd262144, 35'sd131072, 35'sd65536, 35'sd32768,
      35'sd16384, 35'sd8192, 35'sd4096, 35'sd2048,
      35'sd1024, 35'sd512, 35'sd256, 35'sd128
   };

   typedef struct packed {
      logic signed [SW-1:0] roll_num;
      logic signed [SW-1:0] roll_den;
      logic signed [SW-1:0] yaw_num;
      logic signed [SW-1:0] yaw_den;
      logic signed [AW-1:0] asin_arg;
      logic                 sat;
   } sqrt_payload_type;

   typedef struct packed {
      logic [RADW-1:0] rem;
      logic [RESW-1:0] res;
   } sqrt_state_type;

   typedef struct packed {
      logic signed [XYW-1:0] x;
      logic signed [XYW-1:0] y;
      logic signed [ZW-1:0]  z;
      logic                  zero;
   } lane_type;

   // quadrant fold ahead of the vectoring cells
   function automatic lane_type cordic_init(input logic signed [SW-1:0] y,
                                            input logic signed [SW-1:0] x);
      lane_type l;
      l.zero = (x == '0) && (y == '0);
      l.x    = XYW'(x);
      l.y    = XYW'(y);
      l.z    = '0;
      if (x < 0) begin
         l.z = (y >= 0) ? PI_Q30 : -PI_Q30;
         l.x = -l.x;
         l.y = -l.y;
      end
      return l;
   endfunction

   // round half up from q.30 to q3.13, then clamp
   function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] z,
                                                 input logic signed [ZW-1:0] lim);
      logic signed [ZW-1:0] q;
      q = (z + ROUND_Q30) >>> Q13_SHIFT;
      if (q > lim) begin
         q = lim;
      end
      if (q < -lim) begin
         q = -lim;
      end
      return q[15:0];
   endfunction

endpackage

`default_nettype wire

/* design/q2e_sqrt_cell.sv */
// ---------------------------------------------------------------------------
// q2e_sqrt_cell
// one restoring square root step, one result bit, with payload carried along
// ---------------------------------------------------------------------------
`default_nettype none

module q2e_sqrt_cell #(
   parameter int STEP = 0
) (
   input  wire logic                        clock,
   input  wire logic                        enable,
   input  wire q2e_pkg::sqrt_state_type     state_in,
   input  wire q2e_pkg::sqrt_payload_type   payload_in,
   output q2e_pkg::sqrt_state_type          state_out,
   output q2e_pkg::sqrt_payload_type        payload_out
);

   localparam logic [q2e_pkg::RESW-1:0] BIT_VAL =
      q2e_pkg::RESW'(1) << (q2e_pkg::RADW - 1 - 2 * STEP);

   q2e_pkg::sqrt_state_type   state_in_c;
   q2e_pkg::sqrt_state_type   state_ff;
   q2e_pkg::sqrt_payload_type payload_ff;
   logic [q2e_pkg::RESW-1:0]  trial;

   always_comb begin
      trial      = state_in.res + BIT_VAL;
      state_in_c = state_in;
      if ({1'b0, state_in.rem} >= trial) begin
         state_in_c.rem = state_in.rem - trial[q2e_pkg::RADW-1:0];
         state_in_c.res = (state_in.res >> 1) + BIT_VAL;
      end else begin
         state_in_c.res = state_in.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         state_ff   <= state_in_c;
         payload_ff <= payload_in;
      end
   end

   assign state_out   = state_ff;
   assign payload_out = payload_ff;

endmodule

`default_nettype wire

/* design/q2e_cordic_cell.sv */
// ---------------------------------------------------------------------------
// q2e_cordic_cell
// one vectoring micro-rotation of one atan2 lane
// ---------------------------------------------------------------------------
`default_nettype none

module q2e_cordic_cell #(
   parameter int STAGE = 0
) (
   input  wire logic                clock,
   input  wire logic                enable,
   input  wire q2e_pkg::lane_type   lane_in,
   output q2e_pkg::lane_type        lane_out
);

   q2e_pkg::lane_type            lane_in_c;
   q2e_pkg::lane_type            lane_ff;
   logic signed [q2e_pkg::XYW-1:0] dx;
   logic signed [q2e_pkg::XYW-1:0] dy;

   always_comb begin
      dx        = lane_in.y >>> STAGE;
      dy        = lane_in.x >>> STAGE;
      lane_in_c = lane_in;
      if (lane_in.y >= 0) begin
         lane_in_c.x = lane_in.x + dx;
         lane_in_c.y = lane_in.y - dy;
         lane_in_c.z = lane_in.z + q2e_pkg::ATAN_Q30[STAGE];
      end else begin
         lane_in_c.x = lane_in.x - dx;
         lane_in_c.y = lane_in.y + dy;
         lane_in_c.z = lane_in.z - q2e_pkg::ATAN_Q30[STAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in_c;
      end
   end

   assign lane_out = lane_ff;

endmodule

`default_nettype wire

/* design/quaternion_to_euler_angles.sv */
// ---------------------------------------------------------------------------
// quaternion_to_euler_angles
// zyx quaternion to roll, pitch and yaw through a chain of cordic cells
// ---------------------------------------------------------------------------
// Fully pipelined: one quaternion transfer per cycle while not stalled, one
// result per input. The pipeline is five front stages (alignment, products,
// sums with arcsine clamp, a*a, radicand), 29 square root cells, one
// quadrant fold stage, CORDIC_STAGES vectoring cells and the output
// register. The whole pipeline advances together; it holds
// only while a result waits in the output register with rsp_stall high, and
// req_stall is high exactly then. Roll and yaw are four-quadrant atan2 of
// exact q.28 products; pitch is atan2(a, sqrt(1 - a*a)) with a clamped to
// plus or minus one, and rsp_pitch_saturated flags the clamp.
`default_nettype none

module quaternion_to_euler_angles #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int CORDIC_STAGES   = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_quat_real,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_quat_i,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_quat_j,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_quat_k,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [15:0]                     rsp_roll_angle,
   output logic signed [14:0]                     rsp_pitch_angle,
   output logic signed [15:0]                     rsp_yaw_angle,
   output logic                                   rsp_pitch_saturated
);

   localparam int QW    = q2e_pkg::QW;
   localparam int PW    = q2e_pkg::PW;
   localparam int SW    = q2e_pkg::SW;
   localparam int DEPTH = 5 + q2e_pkg::SQRT_STEPS + 1 + CORDIC_STAGES;

   // global advance: stop only when a finished result is held up
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // valid shift line alongside the data
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   assign valid_in = {valid_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff[DEPTH-1];
      end
   end

   // stage 1: align components to q2.14 (floor when wider)
   logic signed [QW-1:0] w_in, x_in, y_in, z_in;
   logic signed [QW-1:0] w_ff, x_ff, y_ff, z_ff;

   generate
      if (COMPONENT_WIDTH >= QW) begin : g_narrow
         assign w_in = QW'(req_quat_real >>> (COMPONENT_WIDTH - QW));
         assign x_in = QW'(req_quat_i    >>> (COMPONENT_WIDTH - QW));
         assign y_in = QW'(req_quat_j    >>> (COMPONENT_WIDTH - QW));
         assign z_in = QW'(req_quat_k    >>> (COMPONENT_WIDTH - QW));
      end else begin : g_widen
         assign w_in = QW'(req_quat_real) <<< (QW - COMPONENT_WIDTH);
         assign x_in = QW'(req_quat_i)    <<< (QW - COMPONENT_WIDTH);
         assign y_in = QW'(req_quat_j)    <<< (QW - COMPONENT_WIDTH);
         assign z_in = QW'(req_quat_k)    <<< (QW - COMPONENT_WIDTH);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff <= w_in;
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   // stage 2: the nine products, exact in q.28
   logic signed [PW-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= PW'(w_ff) * PW'(x_ff);
         yz_ff <= PW'(y_ff) * PW'(z_ff);
         xx_ff <= PW'(x_ff) * PW'(x_ff);
         yy_ff <= PW'(y_ff) * PW'(y_ff);
         wy_ff <= PW'(w_ff) * PW'(y_ff);
         zx_ff <= PW'(z_ff) * PW'(x_ff);
         wz_ff <= PW'(w_ff) * PW'(z_ff);
         xy_ff <= PW'(x_ff) * PW'(y_ff);
         zz_ff <= PW'(z_ff) * PW'(z_ff);
      end
   end

   // stage 3: atan2 arguments and the clamped arcsine argument
   q2e_pkg::sqrt_payload_type p3_in, p3_ff;
   logic signed [SW-1:0]      asin_raw;

   always_comb begin
      p3_in.roll_num = (SW'(wx_ff) + SW'(yz_ff)) <<< 1;
      p3_in.roll_den = q2e_pkg::ONE_Q28 - ((SW'(xx_ff) + SW'(yy_ff)) <<< 1);
      p3_in.yaw_num  = (SW'(wz_ff) + SW'(xy_ff)) <<< 1;
      p3_in.yaw_den  = q2e_pkg::ONE_Q28 - ((SW'(yy_ff) + SW'(zz_ff)) <<< 1);
      asin_raw       = (SW'(wy_ff) - SW'(zx_ff)) <<< 1;
      priority if (asin_raw > q2e_pkg::ONE_Q28) begin
         p3_in.asin_arg = q2e_pkg::ONE_Q28[q2e_pkg::AW-1:0];
         p3_in.sat      = 1'b1;
      end else if (asin_raw < -q2e_pkg::ONE_Q28) begin
         p3_in.asin_arg = q2e_pkg::AW'(-q2e_pkg::ONE_Q28);
         p3_in.sat      = 1'b1;
      end else begin
         p3_in.asin_arg = asin_raw[q2e_pkg::AW-1:0];
         p3_in.sat      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p3_ff <= p3_in;
      end
   end

   // stage 4: a*a; stage 5: radicand 2^56 - a*a
   q2e_pkg::sqrt_payload_type        p4_ff, p5_ff;
   logic signed [2*q2e_pkg::AW-1:0]  asq_full;
   logic [q2e_pkg::RADW-1:0]         asq_ff, rad_ff;

   assign asq_full = p3_ff.asin_arg * p3_ff.asin_arg;

   always_ff @(posedge clock) begin
      if (en) begin
         p4_ff  <= p3_ff;
         asq_ff <= asq_full[q2e_pkg::RADW-1:0];
         p5_ff  <= p4_ff;
         rad_ff <= (q2e_pkg::RADW'(1) << (q2e_pkg::RADW - 1)) - asq_ff;
      end
   end

   // square root chain, one result bit per cell
   q2e_pkg::sqrt_state_type   sq_state   [0:q2e_pkg::SQRT_STEPS];
   q2e_pkg::sqrt_payload_type sq_payload [0:q2e_pkg::SQRT_STEPS];

   assign sq_state[0].rem = rad_ff;
   assign sq_state[0].res = '0;
   assign sq_payload[0]   = p5_ff;

   generate
      for (genvar k = 0; k < q2e_pkg::SQRT_STEPS; k++) begin : g_sqrt
         q2e_sqrt_cell #(.STEP(k)) u_cell (
            .clock       (clock),
            .enable      (en),
            .state_in    (sq_state[k]),
            .payload_in  (sq_payload[k]),
            .state_out   (sq_state[k+1]),
            .payload_out (sq_payload[k+1])
         );
      end
   endgenerate

   // quadrant fold for the three atan2 lanes
   q2e_pkg::sqrt_payload_type sq_last;
   logic signed [SW-1:0]      root_arg;
   logic signed [SW-1:0]      asin_ext;
   q2e_pkg::lane_type         roll_lane [0:CORDIC_STAGES];
   q2e_pkg::lane_type         pitch_lane [0:CORDIC_STAGES];
   q2e_pkg::lane_type         yaw_lane [0:CORDIC_STAGES];
   q2e_pkg::lane_type         roll_init_ff, pitch_init_ff, yaw_init_ff;
   logic                      sat_ff [0:CORDIC_STAGES];

   assign sq_last  = sq_payload[q2e_pkg::SQRT_STEPS];
   assign root_arg = {{(SW - q2e_pkg::ROOTW){1'b0}},
                      sq_state[q2e_pkg::SQRT_STEPS].res[q2e_pkg::ROOTW-1:0]};
   assign asin_ext = SW'(sq_last.asin_arg);

   always_ff @(posedge clock) begin
      if (en) begin
         roll_init_ff  <= q2e_pkg::cordic_init(sq_last.roll_num, sq_last.roll_den);
         pitch_init_ff <= q2e_pkg::cordic_init(asin_ext, root_arg);
         yaw_init_ff   <= q2e_pkg::cordic_init(sq_last.yaw_num, sq_last.yaw_den);
         sat_ff[0]     <= sq_last.sat;
      end
   end

   assign roll_lane[0]  = roll_init_ff;
   assign pitch_lane[0] = pitch_init_ff;
   assign yaw_lane[0]   = yaw_init_ff;

   // vectoring chain, three lanes side by side
   generate
      for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
         q2e_cordic_cell #(.STAGE(s)) u_roll (
            .clock (clock), .enable (en),
            .lane_in (roll_lane[s]), .lane_out (roll_lane[s+1])
         );
         q2e_cordic_cell #(.STAGE(s)) u_pitch (
            .clock (clock), .enable (en),
            .lane_in (pitch_lane[s]), .lane_out (pitch_lane[s+1])
         );
         q2e_cordic_cell #(.STAGE(s)) u_yaw (
            .clock (clock), .enable (en),
            .lane_in (yaw_lane[s]), .lane_out (yaw_lane[s+1])
         );
         always_ff @(posedge clock) begin
            if (en) begin
               sat_ff[s+1] <= sat_ff[s];
            end
         end
      end
   endgenerate

   // output register: round, clamp, zero case for a null vector
   q2e_pkg::lane_type   roll_last, pitch_last, yaw_last;
   logic signed [15:0]  roll_q, pitch_q, yaw_q;
   logic signed [15:0]  roll_ff, yaw_ff;
   logic signed [14:0]  pitch_ff;
   logic                sat_out_ff;

   assign roll_last  = roll_lane[CORDIC_STAGES];
   assign pitch_last = pitch_lane[CORDIC_STAGES];
   assign yaw_last   = yaw_lane[CORDIC_STAGES];

   assign roll_q  = roll_last.zero  ? '0 : q2e_pkg::to_q13(roll_last.z, q2e_pkg::PI_Q13);
   assign pitch_q = pitch_last.zero ? '0 :
                    q2e_pkg::to_q13(pitch_last.z, q2e_pkg::HALF_PI_Q13);
   assign yaw_q   = yaw_last.zero   ? '0 : q2e_pkg::to_q13(yaw_last.z, q2e_pkg::PI_Q13);

   always_ff @(posedge clock) begin
      if (en) begin
         roll_ff    <= roll_q;
         pitch_ff   <= pitch_q[14:0];
         yaw_ff     <= yaw_q;
         sat_out_ff <= sat_ff[CORDIC_STAGES];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_roll_angle      = roll_ff;
   assign rsp_pitch_angle     = pitch_ff;
   assign rsp_yaw_angle       = yaw_ff;
   assign rsp_pitch_saturated = sat_out_ff;

endmodule

`default_nettype wire

/* design/q2e_checker.sv */
// ---------------------------------------------------------------------------
// q2e_port_checker
// port-level checks of the quaternion to euler block, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "quaternion_to_euler_angles_defines.svh"

module q2e_port_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [15:0] rsp_roll_angle,
   input wire logic signed [14:0] rsp_pitch_angle,
   input wire logic signed [15:0] rsp_yaw_angle,
   input wire logic               rsp_pitch_saturated
);

   // a held response keeps its payload
   `Q2E_ASSERT_CLK(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_roll_angle) && $stable(rsp_pitch_angle) && $stable(rsp_yaw_angle) && $stable(rsp_pitch_saturated)), "stalled response changed")

   // input back-pressure only while a result is held up
   `Q2E_ASSERT_IMPLIES(a_req_stall_cause, req_stall, rsp_valid && rsp_stall, "input stalled without a held response")

   // angles stay within their clamped ranges
   `Q2E_ASSERT_IMPLIES(a_angle_range, rsp_valid, (rsp_roll_angle <= 16'sd25736) && (rsp_roll_angle >= -16'sd25736) && (rsp_yaw_angle <= 16'sd25736) && (rsp_yaw_angle >= -16'sd25736) && (rsp_pitch_angle <= 15'sd12868) && (rsp_pitch_angle >= -15'sd12868), "angle out of range")

endmodule

bind quaternion_to_euler_angles q2e_port_checker u_q2e_checker (.*);

`default_nettype wire

/* tb/q2e_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// q2e_checker
// watches both channels, predicts roll, pitch and yaw, compares each result
// ---------------------------------------------------------------------------
`default_nettype none

module q2e_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic signed [15:0] req_quat_real,
   input  wire logic signed [15:0] req_quat_i,
   input  wire logic signed [15:0] req_quat_j,
   input  wire logic signed [15:0] req_quat_k,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic signed [15:0] rsp_roll_angle,
   input  wire logic signed [14:0] rsp_pitch_angle,
   input  wire logic signed [15:0] rsp_yaw_angle,
   input  wire logic               rsp_pitch_saturated,
   output int                      failures,
   output int                      pending
);

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic               sat;
   } angles_type;

   localparam longint ONE_Q28  = 64'sd268435456;
   localparam longint PI_Q30   = 64'sd3373259426;
   localparam longint PI_Q13   = 64'sd25736;
   localparam longint HPI_Q13  = 64'sd12868;
   localparam int     STAGES   = 16;

   localparam longint ARCTAN [0:15] = '{
      64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
      64'sd67021687, 64'sd33543516, 64'sd16775851, 64'sd8388437,
      64'sd4194283, 64'sd2097149, 64'sd1048576, 64'sd524288,
      64'sd262144, 64'sd131072, 64'sd65536, 64'sd32768
   };

   angles_type expected_angles[$];

   // four-quadrant arctangent by cordic vectoring, q.30 radians
   function automatic longint arctan2(input longint y_in, input longint x_in);
      longint x, y, z, dx, dy;
      x = x_in;
      y = y_in;
      z = 0;
      if (x == 0 && y == 0) begin
         return 0;
      end
      if (x < 0) begin
         z = (y >= 0) ? PI_Q30 : -PI_Q30;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + ARCTAN[i];
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - ARCTAN[i];
         end
      end
      return z;
   endfunction

   function automatic longint round_q13(input longint z, input longint lim);
      longint q;
      q = (z + 64'sd65536) >>> 17;
      if (q > lim) begin
         q = lim;
      end
      if (q < -lim) begin
         q = -lim;
      end
      return q;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v_in);
      longint unsigned v, res, bitv;
      v    = v_in;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) begin
         bitv = bitv >> 2;
      end
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic angles_type euler_from_quat(input logic signed [15:0] qw,
                                                  input logic signed [15:0] qx,
                                                  input logic signed [15:0] qy,
                                                  input logic signed [15:0] qz);
      longint w, x, y, z, a, r;
      longint unsigned root;
      angles_type ang;
      w = qw;
      x = qx;
      y = qy;
      z = qz;
      ang.sat = 1'b0;
      r = round_q13(arctan2(2 * (w * x + y * z), ONE_Q28 - 2 * (x * x + y * y)), PI_Q13);
      ang.roll = r[15:0];
      a = 2 * (w * y - z * x);
      // arcsine argument clamped to unit magnitude
      if (a > ONE_Q28) begin
         a = ONE_Q28;
         ang.sat = 1'b1;
      end else if (a < -ONE_Q28) begin
         a = -ONE_Q28;
         ang.sat = 1'b1;
      end
      root = int_sqrt((64'd1 << 56) - longint'(a * a));
      r = round_q13(arctan2(a, longint'(root)), HPI_Q13);
      ang.pitch = r[14:0];
      r = round_q13(arctan2(2 * (w * z + x * y), ONE_Q28 - 2 * (y * y + z * z)), PI_Q13);
      ang.yaw = r[15:0];
      return ang;
   endfunction

   always @(posedge clock) begin
      angles_type exp_a;
      int         errs;
      errs = 0;
      if (reset) begin
         failures <= 0;
         pending  <= 0;
         expected_angles.delete();
      end else begin
         if (req_valid && !req_stall) begin
            expected_angles.push_back(euler_from_quat(req_quat_real, req_quat_i,
                                                      req_quat_j, req_quat_k));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_angles.size() == 0) begin
               $error("result transfer with no quaternion outstanding");
               errs = errs + 1;
            end else begin
               exp_a = expected_angles.pop_front();
               if (exp_a.roll !== rsp_roll_angle) begin
                  $error("roll_angle expected %0d actual %0d", exp_a.roll, rsp_roll_angle);
                  errs = errs + 1;
               end
               if (exp_a.pitch !== rsp_pitch_angle) begin
                  $error("pitch_angle expected %0d actual %0d",
                         exp_a.pitch, rsp_pitch_angle);
                  errs = errs + 1;
               end
               if (exp_a.yaw !== rsp_yaw_angle) begin
                  $error("yaw_angle expected %0d actual %0d", exp_a.yaw, rsp_yaw_angle);
                  errs = errs + 1;
               end
               if (exp_a.sat !== rsp_pitch_saturated) begin
                  $error("pitch_saturated expected %0d actual %0d",
                         exp_a.sat, rsp_pitch_saturated);
                  errs = errs + 1;
               end
            end
         end
         failures <= failures + errs;
         pending  <= expected_angles.size();
      end
   end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the quaternion to euler angle pipeline
// ---------------------------------------------------------------------------
// Directed quaternions cover the component extremes, both-zero and negative
// axis arctangent cases and the clamped arcsine, then around 1200 random
// ones, mostly unit quaternions near and away from gimbal lock. Both sides
// idle in random bursts; the last part runs flat out. The checker beside the
// block predicts every result and counts failures.
`default_nettype none

module tb_top;

   localparam int N_RANDOM   = 1200;
   localparam int WATCHDOG   = 3000;   // cycles without any transfer
   localparam int DRAIN_WAIT = 60;     // extra wait after the last result

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_quat_real = '0;
   logic signed [15:0] req_quat_i = '0;
   logic signed [15:0] req_quat_j = '0;
   logic signed [15:0] req_quat_k = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_roll_angle;
   logic signed [14:0] rsp_pitch_angle;
   logic signed [15:0] rsp_yaw_angle;
   logic               rsp_pitch_saturated;

   int  failures;
   int  pending;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;     // no idling in the last part of the run

   always #2 clock = ~clock;

   quaternion_to_euler_angles u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_quat_real       (req_quat_real),
      .req_quat_i          (req_quat_i),
      .req_quat_j          (req_quat_j),
      .req_quat_k          (req_quat_k),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_roll_angle      (rsp_roll_angle),
      .rsp_pitch_angle     (rsp_pitch_angle),
      .rsp_yaw_angle       (rsp_yaw_angle),
      .rsp_pitch_saturated (rsp_pitch_saturated)
   );

   q2e_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_quat_real       (req_quat_real),
      .req_quat_i          (req_quat_i),
      .req_quat_j          (req_quat_j),
      .req_quat_k          (req_quat_k),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_roll_angle      (rsp_roll_angle),
      .rsp_pitch_angle     (rsp_pitch_angle),
      .rsp_yaw_angle       (rsp_yaw_angle),
      .rsp_pitch_saturated (rsp_pitch_saturated),
      .failures            (failures),
      .pending             (pending)
   );

   // receiver stalls in bursts, switched off for the last part
   always @(negedge clock) begin
      int stall_left;
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall  <= (stall_left != 0);
      end else if ($urandom_range(0, 15) == 0) begin
         stall_left = $urandom_range(1, 19);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on transfers of either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("quaternion_to_euler_angles: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one quaternion transfer; inputs move at the falling edge only
   task automatic send_quat(input int qw, input int qx, input int qy, input int qz);
      req_valid     <= 1'b1;
      req_quat_real <= 16'(qw);
      req_quat_i    <= 16'(qx);
      req_quat_j    <= 16'(qy);
      req_quat_k    <= 16'(qz);
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 11) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
   endtask

   function automatic int clip_component(input real v);
      int r;
      r = $rtoi(v < 0.0 ? v - 0.5 : v + 0.5);
      if (r > 16384) begin
         r = 16384;
      end
      if (r < -16384) begin
         r = -16384;
      end
      return r;
   endfunction

   // random quaternion: mostly unit length, some near gimbal lock, some raw
   task automatic send_random_quat();
      real c[4];
      real norm, gain;
      int  kind;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         send_quat($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                   $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
      end else begin
         for (int i = 0; i < 4; i++) begin
            c[i] = real'(int'($urandom_range(0, 20000)) - 10000);
         end
         if (kind == 2) begin
            // pitch near plus or minus ninety degrees
            c[2] = ($urandom_range(0, 1) ? c[0] : -c[0]) + real'($urandom_range(0, 40));
            c[3] = ($urandom_range(0, 1) ? c[1] : -c[1]);
         end
         norm = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
         if (norm < 1.0) begin
            norm = 1.0;
         end
         gain = (kind == 3) ? 0.9 + 0.2 * real'($urandom_range(0, 1000)) / 1000.0 : 1.0;
         send_quat(clip_component(16384.0 * gain * c[0] / norm),
                   clip_component(16384.0 * gain * c[1] / norm),
                   clip_component(16384.0 * gain * c[2] / norm),
                   clip_component(16384.0 * gain * c[3] / norm));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: identity, axis half-turns, extremes, zero, clamped arcsine
      send_quat(16384, 0, 0, 0);
      send_quat(-16384, 0, 0, 0);
      send_quat(0, 16384, 0, 0);
      send_quat(0, 0, 16384, 0);
      send_quat(0, 0, 0, 16384);
      send_quat(0, -16384, 0, 0);
      send_quat(0, 0, 0, -16384);
      send_quat(0, 0, 0, 0);
      send_quat(16384, 16384, 16384, 16384);
      send_quat(-16384, -16384, -16384, -16384);
      send_quat(16384, 0, 16384, 0);
      send_quat(16384, 0, -16384, 0);
      send_quat(0, 16384, 0, -16384);
      send_quat(11585, 0, 11585, 0);
      send_quat(11585, 0, -11585, 0);
      send_quat(11586, 0, 11586, 0);
      send_quat(8192, 8192, 8192, 8192);
      send_quat(16384, -16384, 16384, -16384);
      send_quat(1, -1, 1, -1);
      send_quat(-16384, 16384, -1, 1);
      send_quat(21, 5461, 10922, 16383);

      for (int n = 0; n < N_RANDOM; n++) begin
         // hold off once until the pipeline has drained
         if (n == N_RANDOM / 2) begin
            req_valid <= 1'b0;
            while (pending != 0) begin
               @(negedge clock);
            end
         end
         if (n == N_RANDOM - 200) begin
            quiet = 1'b1;
         end
         send_random_quat();
      end
      req_valid <= 1'b0;

      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);
      if (failures == 0) begin
         $display("quaternion_to_euler_angles: match");
      end else begin
         $display("quaternion_to_euler_angles: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
+incdir+design
design/q2e_pkg.sv
design/q2e_sqrt_cell.sv
design/q2e_cordic_cell.sv
design/quaternion_to_euler_angles.sv
design/q2e_checker.sv
tb/q2e_checker.sv
tb/tb_top.sv
